@@ hdl/slt_pkg.sv @@
package slt_pkg;

    localparam int OP_BITS      = 3;
    localparam int KEY_BITS     = 16;
    localparam int HIN_BITS     = 32;
    localparam int RIDX_BITS    = 9;
    localparam int IDX_BITS     = 9;
    localparam int CNT_BITS     = 10;
    localparam int STAT_BITS    = 2;
    localparam int WIDE_BITS    = 13;
    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 72;

    typedef logic [OP_BITS-1:0]   t_op;
    typedef logic [STAT_BITS-1:0] t_status;

    localparam t_op OP_STORE  = 3'd0;
    localparam t_op OP_DELETE = 3'd1;
    localparam t_op OP_FIND   = 3'd2;
    localparam t_op OP_READ   = 3'd3;
    localparam t_op OP_CLEAR  = 3'd4;

    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_FULL      = 2'd1;
    localparam t_status STAT_NOT_FOUND = 2'd2;
    localparam t_status STAT_BAD_INDEX = 2'd3;

endpackage

@@ hdl/slt_ram.sv @@
module slt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/sorted_line_table.sv @@
// Sorted line table: keeps up to TABLE_DEPTH entries in ascending order of a 16-bit line
// number, each with a payload handle, and answers every request with exactly one result.
// Requests are taken one at a time; the table is held in a single RAM with one read and
// one write port, and a small sequencer walks it one entry per cycle. A store, delete or
// find scans from the bottom for the first entry not below the key; an insert or delete
// then moves each later entry by one place at one entry per cycle, an insert from the top
// entry down to where the scan stopped, a delete from the entry above the deleted one
// upwards. A read fetches the entry at its index, and a clear empties the table. A
// finished result waits in the output register while the next request is taken.
module sorted_line_table
    import slt_pkg::*;
#(
    parameter int TABLE_DEPTH = 512,
    parameter int HANDLE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // line_number[15:0], payload_handle[47:16], read_index[56:48], zero[63:57]
    input  logic [S_TDATA_BITS-1:0] i_s_tdata,
    // op[2:0]
    input  logic [OP_BITS-1:0]      i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // entry_index[8:0], entry_number[24:9], entry_handle[56:25], entry_count[66:57],
    // zero[71:67]
    output logic [M_TDATA_BITS-1:0] o_m_tdata,
    // status[1:0]
    output logic [STAT_BITS-1:0]    o_m_tuser
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KEY_BITS + HANDLE_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_WRNEW  = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_pend, n_pend;
    logic                   r_more, n_more;
    logic                   r_out_valid, n_out_valid;

    t_op                    r_op, n_op;
    logic [KEY_BITS-1:0]    r_num, n_num;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_end, n_end;
    logic [CW-1:0]          r_pend_idx, n_pend_idx;
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_up, n_up;
    t_status                r_res_status, n_res_status;
    logic [CW-1:0]          r_res_idx, n_res_idx;
    logic [KEY_BITS-1:0]    r_res_num, n_res_num;
    logic [HANDLE_BITS-1:0] r_res_handle, n_res_handle;
    t_status                r_out_status, n_out_status;
    logic [IDX_BITS-1:0]    r_out_idx, n_out_idx;
    logic [KEY_BITS-1:0]    r_out_num, n_out_num;
    logic [HIN_BITS-1:0]    r_out_handle, n_out_handle;
    logic [CNT_BITS-1:0]    r_out_count, n_out_count;

    logic                   w_accept;
    logic                   w_out_free;
    t_op                    w_in_op;
    logic [KEY_BITS-1:0]    w_in_num;
    logic [HIN_BITS-1:0]    w_in_handle;
    logic [RIDX_BITS-1:0]   w_in_ridx;
    logic                   w_wr_en;
    logic [IW-1:0]          w_wr_addr;
    logic [EW-1:0]          w_wr_data;
    logic [IW-1:0]          w_rd_addr;
    logic [EW-1:0]          w_rd_data;
    logic [KEY_BITS-1:0]    w_q_key;
    logic [HANDLE_BITS-1:0] w_q_handle;
    logic                   w_found;
    logic                   w_hit;
    logic                   w_scan_end;
    logic [CW-1:0]          w_pos;

    assign w_in_op     = i_s_tuser;
    assign w_in_num    = i_s_tdata[15:0];
    assign w_in_handle = i_s_tdata[47:16];
    assign w_in_ridx   = i_s_tdata[56:48];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_rd_addr  = (r_state == S_IDLE) ? IW'(w_in_ridx) : IW'(r_ptr);
    assign w_q_key    = w_rd_data[EW-1:HANDLE_BITS];
    assign w_q_handle = w_rd_data[HANDLE_BITS-1:0];

    assign w_found    = r_pend && (w_q_key >= r_num);
    assign w_hit      = w_found && (w_q_key == r_num);
    assign w_scan_end = w_found || (r_ptr == r_count);
    assign w_pos      = w_found ? r_pend_idx : r_count;

    slt_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pend       = r_pend;
        n_more       = r_more;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_num        = r_num;
        n_handle     = r_handle;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_pend_idx   = r_pend_idx;
        n_pos        = r_pos;
        n_up         = r_up;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_num    = r_res_num;
        n_res_handle = r_res_handle;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_num    = r_out_num;
        n_out_handle = r_out_handle;
        n_out_count  = r_out_count;
        w_wr_en      = 1'b0;
        w_wr_addr    = IW'(r_pend_idx);
        w_wr_data    = w_rd_data;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op         = w_in_op;
                    n_num        = w_in_num;
                    n_handle     = HANDLE_BITS'(w_in_handle);
                    n_ptr        = '0;
                    n_pend       = 1'b0;
                    n_more       = 1'b0;
                    n_res_status = STAT_OK;
                    n_res_idx    = '0;
                    n_res_num    = '0;
                    n_res_handle = '0;
                    case (w_in_op)
                        OP_STORE, OP_DELETE, OP_FIND: begin
                            n_state = S_SCAN;
                        end
                        OP_READ: begin
                            if (WIDE_BITS'(w_in_ridx) < WIDE_BITS'(r_count)) begin
                                n_res_idx = CW'(w_in_ridx);
                                n_state   = S_RDWAIT;
                            end else begin
                                n_res_status = STAT_BAD_INDEX;
                                n_state      = S_RESP;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_scan_end) begin
                    n_ptr      = r_ptr + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr;
                end else begin
                    n_pos  = w_pos;
                    n_pend = 1'b0;
                    case (r_op)
                        OP_STORE: begin
                            if (w_hit) begin
                                w_wr_en      = 1'b1;
                                w_wr_addr    = IW'(w_pos);
                                w_wr_data    = {r_num, r_handle};
                                n_res_idx    = w_pos;
                                n_res_num    = r_num;
                                n_res_handle = r_handle;
                                n_state      = S_RESP;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_res_status = STAT_FULL;
                                n_state      = S_RESP;
                            end else begin
                                n_res_idx    = w_pos;
                                n_res_num    = r_num;
                                n_res_handle = r_handle;
                                n_up         = 1'b1;
                                n_ptr        = r_count - CW'(1);
                                n_end        = w_pos;
                                n_more       = (w_pos != r_count);
                                n_state      = S_SHIFT;
                            end
                        end
                        OP_DELETE, OP_FIND: begin
                            if (!w_hit) begin
                                n_res_status = STAT_NOT_FOUND;
                                n_state      = S_RESP;
                            end else begin
                                n_res_idx    = w_pos;
                                n_res_num    = w_q_key;
                                n_res_handle = w_q_handle;
                                if (r_op == OP_DELETE) begin
                                    n_up    = 1'b0;
                                    n_ptr   = w_pos + CW'(1);
                                    n_end   = r_count - CW'(1);
                                    n_more  = ((w_pos + CW'(1)) != r_count);
                                    n_state = S_SHIFT;
                                end else begin
                                    n_state = S_RESP;
                                end
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_up ? IW'(r_pend_idx + CW'(1)) : IW'(r_pend_idx - CW'(1));
                    w_wr_data = w_rd_data;
                end
                if (r_more) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr;
                    if (r_ptr == r_end) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_up ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_up) begin
                            n_state = S_WRNEW;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_RESP;
                        end
                    end
                end
            end
            S_WRNEW: begin
                w_wr_en   = 1'b1;
                w_wr_addr = IW'(r_pos);
                w_wr_data = {r_num, r_handle};
                n_count   = r_count + CW'(1);
                n_state   = S_RESP;
            end
            S_RDWAIT: begin
                n_res_num    = w_q_key;
                n_res_handle = w_q_handle;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = IDX_BITS'(r_res_idx);
                    n_out_num    = r_res_num;
                    n_out_handle = HIN_BITS'(r_res_handle);
                    n_out_count  = CNT_BITS'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_num        <= n_num;
        r_handle     <= n_handle;
        r_ptr        <= n_ptr;
        r_end        <= n_end;
        r_pend_idx   <= n_pend_idx;
        r_pos        <= n_pos;
        r_up         <= n_up;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_num    <= n_res_num;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_num    <= n_out_num;
        r_out_handle <= n_out_handle;
        r_out_count  <= n_out_count;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {5'b0, r_out_count, r_out_handle, r_out_num, r_out_idx};

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count == $past(r_count) - CW'(1)) || (r_count == '0))
        else $error("entry count moved by more than one");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_in_op == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear request left entries in the table");

    a_shift_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && w_wr_en) |-> (CW'(w_wr_addr) <= r_count))
        else $error("shift wrote beyond the used entries");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESP) && (r_res_status == STAT_FULL)) |->
        (r_count == CW'(TABLE_DEPTH)))
        else $error("full status with room left");
`endif

endmodule
